// ===== design/jaec_pkg.sv =====
// Package for the JSON array element counter.
// Holds byte classes, status codes, the queue item type and sizing constants.
// No dependencies.
package jaec_pkg;

	localparam int MAX_DEPTH    = 255;
	localparam longint MAX_ELEMENTS = 65535;
	localparam int COUNT_W      = 16;
	localparam int DEPTH_W      = $clog2(MAX_DEPTH + 1);
	localparam int COUNT_LIMIT  = (MAX_ELEMENTS > 65535) ? 65535 : int'(MAX_ELEMENTS);
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_QUOTE       = 8'h22;
	localparam logic [7:0] CH_BSLASH      = 8'h5C;
	localparam logic [7:0] CH_OPEN_CURLY  = 8'h7B;
	localparam logic [7:0] CH_OPEN_SQ     = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQ    = 8'h5D;
	localparam logic [7:0] CH_CLOSE_CURLY = 8'h7D;
	localparam logic [7:0] CH_COMMA       = 8'h2C;
	localparam logic [7:0] CH_SPACE       = 8'h20;
	localparam logic [7:0] CH_TAB         = 8'h09;
	localparam logic [7:0] CH_CR          = 8'h0D;

	typedef enum logic [2:0] {
		CLS_QUOTE,
		CLS_BSLASH,
		CLS_OPEN,
		CLS_CLOSE_SQ,
		CLS_CLOSE_CURLY,
		CLS_COMMA,
		CLS_BLANK,
		CLS_OTHER
	} byte_cls_t;

	typedef enum logic [2:0] {
		ST_SCANNING    = 3'd0,
		ST_CLOSED      = 3'd1,
		ST_OPEN_STRING = 3'd2,
		ST_NO_BEGIN    = 3'd3,
		ST_EMPTY_COMMA = 3'd4,
		ST_NO_END      = 3'd5,
		ST_TOO_DEEP    = 3'd6
	} scan_status_t;

	typedef struct packed {
		byte_cls_t cls;
		logic      first;
		logic      last;
	} scan_item_t;

endpackage

// ===== design/json_array_element_counter_top.sv =====
// Top level of the JSON array element counter.
// Depends on jaec_pkg, jaec_front, jaec_queue and jaec_back.
//
// Scans a JSON array body one byte per request, starting just after the
// opening bracket, and returns one result per request: status, the number
// of top-level elements seen so far (saturating) and a finished flag. A
// request with first set clears the scan and starts over with its byte;
// after the scan ends (closing bracket or error) later bytes are ignored
// and the final result is repeated. Throughput is one request per cycle
// while out_ready holds: the front register classifies the byte, a
// four-entry queue absorbs stalls, and the back part updates the scan
// state, the result register being that state. When the queue is empty
// and the output is drained, a request passes through the front register,
// then a queue entry, then the result register before its result is valid.
module json_array_element_counter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  byte_value,
	input  logic        first,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] element_count,
	output logic        finished
);

	logic                 fr_valid;
	logic                 fr_ready;
	jaec_pkg::scan_item_t fr_item;
	logic                 bk_valid;
	logic                 bk_ready;
	jaec_pkg::scan_item_t bk_item;

	// Classify and register incoming bytes.
	jaec_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.first      (first),
		.last       (last),
		.item_valid (fr_valid),
		.item_ready (fr_ready),
		.item       (fr_item)
	);

	// Hold classified requests while the back part is stalled.
	jaec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_item  (fr_item),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_item   (bk_item)
	);

	// Advance the scan state and present the result.
	jaec_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (bk_valid),
		.item_ready    (bk_ready),
		.item          (bk_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.element_count (element_count),
		.finished      (finished)
	);

endmodule

// ===== design/jaec_front.sv =====
// Front stage of the JSON array element counter: accepts requests and classifies bytes.
// Depends on jaec_pkg.
module jaec_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          byte_value,
	input  logic                first,
	input  logic                last,
	output logic                item_valid,
	input  logic                item_ready,
	output jaec_pkg::scan_item_t item
);

	logic                 valid_s1;
	jaec_pkg::scan_item_t item_s1;
	jaec_pkg::byte_cls_t  cls;

	// Classify the byte into the few kinds the scanner cares about.
	always_comb begin
		if (byte_value == jaec_pkg::CH_QUOTE) begin
			cls = jaec_pkg::CLS_QUOTE;
		end else if (byte_value == jaec_pkg::CH_BSLASH) begin
			cls = jaec_pkg::CLS_BSLASH;
		end else if (byte_value == jaec_pkg::CH_OPEN_CURLY ||
				byte_value == jaec_pkg::CH_OPEN_SQ) begin
			cls = jaec_pkg::CLS_OPEN;
		end else if (byte_value == jaec_pkg::CH_CLOSE_SQ) begin
			cls = jaec_pkg::CLS_CLOSE_SQ;
		end else if (byte_value == jaec_pkg::CH_CLOSE_CURLY) begin
			cls = jaec_pkg::CLS_CLOSE_CURLY;
		end else if (byte_value == jaec_pkg::CH_COMMA) begin
			cls = jaec_pkg::CLS_COMMA;
		end else if (byte_value == jaec_pkg::CH_SPACE ||
				(byte_value >= jaec_pkg::CH_TAB && byte_value <= jaec_pkg::CH_CR)) begin
			cls = jaec_pkg::CLS_BLANK;
		end else begin
			cls = jaec_pkg::CLS_OTHER;
		end
	end

	assign in_ready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= '{cls: cls, first: first, last: last};
		end
	end

endmodule

// ===== design/jaec_queue.sv =====
// Short request queue between the front and back parts of the element counter.
// Depends on jaec_pkg.
module jaec_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  jaec_pkg::scan_item_t push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output jaec_pkg::scan_item_t pop_item
);

	jaec_pkg::scan_item_t              slot_q [jaec_pkg::QUEUE_DEPTH];
	logic [jaec_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [jaec_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [jaec_pkg::QCNT_W-1:0]       fill_q;
	logic                              do_push;
	logic                              do_pop;

	assign push_ready = fill_q != jaec_pkg::QCNT_W'(jaec_pkg::QUEUE_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + jaec_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + jaec_pkg::QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + jaec_pkg::QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - jaec_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== design/jaec_back.sv =====
// Back part of the element counter: scan state update and registered result.
// Depends on jaec_pkg.
module jaec_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  jaec_pkg::scan_item_t        item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  status,
	output logic [jaec_pkg::COUNT_W-1:0] element_count,
	output logic                        finished
);

	logic                         in_quote_q;
	logic                         after_escape_q;
	logic [jaec_pkg::DEPTH_W-1:0] nest_depth_q;
	logic                         awaiting_value_q;
	logic                         element_counted_q;
	logic [jaec_pkg::COUNT_W-1:0] elements_seen_q;
	logic                         scan_over_q;
	jaec_pkg::scan_status_t       end_status_q;
	logic                         out_valid_q;

	logic                         n_quote;
	logic                         n_esc;
	logic [jaec_pkg::DEPTH_W-1:0] n_depth;
	logic                         n_await;
	logic                         n_counted;
	logic [jaec_pkg::COUNT_W-1:0] n_seen;
	logic                         n_over;
	jaec_pkg::scan_status_t       n_status;
	logic                         do_count;
	logic                         take;

	assign item_ready = !out_valid_q || out_ready;
	assign take       = item_valid && item_ready;

	always_comb begin
		if (item.first) begin
			n_quote   = 1'b0;
			n_esc     = 1'b0;
			n_depth   = '0;
			n_await   = 1'b1;
			n_counted = 1'b0;
			n_seen    = '0;
			n_over    = 1'b0;
			n_status  = jaec_pkg::ST_SCANNING;
		end else begin
			n_quote   = in_quote_q;
			n_esc     = after_escape_q;
			n_depth   = nest_depth_q;
			n_await   = awaiting_value_q;
			n_counted = element_counted_q;
			n_seen    = elements_seen_q;
			n_over    = scan_over_q;
			n_status  = end_status_q;
		end
		do_count = 1'b0;

		if (!n_over) begin
			if (n_quote) begin
				if (n_esc) begin
					n_esc = 1'b0;
				end else if (item.cls == jaec_pkg::CLS_BSLASH) begin
					n_esc = 1'b1;
				end else if (item.cls == jaec_pkg::CLS_QUOTE) begin
					n_quote  = 1'b0;
					n_await  = 1'b0;
					do_count = 1'b1;
				end
			end else if (n_depth == '0 && item.cls == jaec_pkg::CLS_CLOSE_SQ) begin
				n_over   = 1'b1;
				n_status = jaec_pkg::ST_CLOSED;
			end else begin
				unique case (item.cls)
					jaec_pkg::CLS_QUOTE: begin
						n_quote = 1'b1;
						n_esc   = 1'b0;
					end
					jaec_pkg::CLS_OPEN: begin
						if (n_depth >= jaec_pkg::DEPTH_W'(jaec_pkg::MAX_DEPTH)) begin
							n_over   = 1'b1;
							n_status = jaec_pkg::ST_TOO_DEEP;
						end else begin
							n_depth  = n_depth + jaec_pkg::DEPTH_W'(1);
							n_await  = 1'b1;
							do_count = 1'b1;
						end
					end
					jaec_pkg::CLS_CLOSE_SQ, jaec_pkg::CLS_CLOSE_CURLY: begin
						if (n_depth == '0) begin
							n_over   = 1'b1;
							n_status = jaec_pkg::ST_NO_BEGIN;
						end else begin
							n_depth  = n_depth - jaec_pkg::DEPTH_W'(1);
							n_await  = 1'b0;
							do_count = 1'b1;
						end
					end
					jaec_pkg::CLS_COMMA: begin
						if (n_await) begin
							n_over   = 1'b1;
							n_status = jaec_pkg::ST_EMPTY_COMMA;
						end else begin
							n_await = 1'b1;
							if (n_depth == '0) begin
								n_counted = 1'b0;
							end
							do_count = 1'b1;
						end
					end
					jaec_pkg::CLS_BLANK: begin
						do_count = 1'b1;
					end
					jaec_pkg::CLS_BSLASH, jaec_pkg::CLS_OTHER: begin
						n_await  = 1'b0;
						do_count = 1'b1;
					end
					default: begin
						do_count = 1'b0;
					end
				endcase
			end

			// Count a top-level element once it has a value behind it.
			if (do_count && n_depth == '0 && !n_counted && !n_await) begin
				if (n_seen < jaec_pkg::COUNT_W'(jaec_pkg::COUNT_LIMIT)) begin
					n_seen = n_seen + jaec_pkg::COUNT_W'(1);
				end
				n_counted = 1'b1;
			end

			if (!n_over && item.last) begin
				n_over   = 1'b1;
				n_status = n_quote ? jaec_pkg::ST_OPEN_STRING : jaec_pkg::ST_NO_END;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q        <= 1'b0;
			after_escape_q    <= 1'b0;
			nest_depth_q      <= '0;
			awaiting_value_q  <= 1'b1;
			element_counted_q <= 1'b0;
			elements_seen_q   <= '0;
			scan_over_q       <= 1'b0;
			end_status_q      <= jaec_pkg::ST_SCANNING;
			out_valid_q       <= 1'b0;
		end else begin
			if (take) begin
				in_quote_q        <= n_quote;
				after_escape_q    <= n_esc;
				nest_depth_q      <= n_depth;
				awaiting_value_q  <= n_await;
				element_counted_q <= n_counted;
				elements_seen_q   <= n_seen;
				scan_over_q       <= n_over;
				end_status_q      <= n_status;
			end
			if (item_ready) begin
				out_valid_q <= item_valid;
			end
		end
	end

	// The result is the state just written, so the output mirrors it.
	assign out_valid     = out_valid_q;
	assign status        = end_status_q;
	assign element_count = elements_seen_q;
	assign finished      = scan_over_q;

endmodule

// ===== design/jaec_checker.sv =====
// Port-level checker for the JSON array element counter, bound to the top level.
// Depends on jaec_pkg and json_array_element_counter_top.
module jaec_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [15:0] element_count,
	input logic        finished
);

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
			$stable(element_count) && $stable(finished))
	else $error("stalled result changed");

	// Finished and a nonzero status go together.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (finished == (status != 3'(jaec_pkg::ST_SCANNING))))
	else $error("finished flag disagrees with status");

	// No status code beyond the last defined one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'(jaec_pkg::ST_TOO_DEEP))
	else $error("undefined status code");

	// Count moves at most by one between consecutive results; a new scan
	// restarts at zero or one, so only larger counts are checked.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready ##1 out_valid && (element_count > 16'd1) |->
			element_count == $past(element_count) ||
			element_count == $past(element_count) + 16'd1)
	else $error("element count jumped");

endmodule

bind json_array_element_counter_top jaec_checker u_jaec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.element_count (element_count),
	.finished      (finished)
);
